/* hdl/jsu_pkg.sv */
package jsu_pkg;

    // Characters that the scanner recognizes.
    localparam logic [15:0] CH_BSL   = 16'h005C;
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_U     = 16'h0075;
    localparam logic [15:0] CH_B     = 16'h0062;
    localparam logic [15:0] CH_F     = 16'h0066;
    localparam logic [15:0] CH_N     = 16'h006E;
    localparam logic [15:0] CH_R     = 16'h0072;
    localparam logic [15:0] CH_T     = 16'h0074;

    // Number of hex digits held before the final digit of a \u escape arrives.
    localparam int HELD_DIGITS = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ESC,
        S_UNI,
        S_PEND,
        S_REPLAY,
        S_RESCAN
    } state_t;

    typedef enum logic [2:0] {
        OSEL_IN,
        OSEL_MAP,
        OSEL_BSL,
        OSEL_CODE,
        OSEL_HELD,
        OSEL_CUR
    } out_sel_t;

    typedef struct packed {
        logic     take;
        logic     store_digit;
        logic     cnt_clear;
        logic     rep_clear;
        logic     rep_inc;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic in_bsl;
        logic in_u;
        logic in_hex;
        logic in_simple;
        logic in_end;
        logic cur_bsl;
        logic cur_end;
        logic cnt_full;
        logic rep_last;
        logic slot_free;
    } status_t;

    // Strict hex digit test: 0-9, a-f, A-F.
    function automatic logic is_hex(input logic [15:0] c);
        return ((c >= 16'h0030) && (c <= 16'h0039)) ||
               ((c >= 16'h0061) && (c <= 16'h0066)) ||
               ((c >= 16'h0041) && (c <= 16'h0046));
    endfunction

    // Value of a hex digit; only meaningful when is_hex holds.
    function automatic logic [3:0] hex_nibble(input logic [15:0] c);
        logic [15:0] v;
        if (c <= 16'h0039) begin
            v = c - 16'h0030;
        end else if (c <= 16'h0046) begin
            v = c - 16'h0037;
        end else begin
            v = c - 16'h0057;
        end
        return v[3:0];
    endfunction

    // True for the characters that form a one-character escape.
    function automatic logic is_simple(input logic [15:0] c);
        logic r;
        case (c) inside
            CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Replacement for a one-character escape.
    function automatic logic [15:0] simple_map(input logic [15:0] c);
        logic [15:0] r;
        case (c)
            CH_B:    r = 16'h0008;
            CH_F:    r = 16'h000C;
            CH_N:    r = 16'h000A;
            CH_R:    r = 16'h000D;
            CH_T:    r = 16'h0009;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

/* hdl/jsu_ctrl.sv */
module jsu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  jsu_pkg::status_t st,
    output jsu_pkg::cmd_t    cmd
);
    import jsu_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input is taken only in the scanning states, and only when the output register has room.
    assign in_ready = st.slot_free &&
                      ((state_reg == S_IDLE) || (state_reg == S_ESC) || (state_reg == S_UNI));
    assign accept   = in_valid && in_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.out_sel     = OSEL_IN;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = accept;
                if (accept)
                begin
                    if (st.in_bsl && !st.in_end)
                    begin
                        state_next = S_ESC;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OSEL_IN;
                        cmd.out_last = st.in_end;
                    end
                end
            end
            S_ESC:
            begin
                cmd.take = accept;
                if (accept)
                begin
                    if (st.in_simple)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OSEL_MAP;
                        cmd.out_last = st.in_end;
                        state_next   = S_IDLE;
                    end
                    else if (st.in_u && !st.in_end)
                    begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = S_UNI;
                    end
                    else
                    begin
                        // Unknown escape: backslash now, the unit itself next.
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OSEL_BSL;
                        state_next   = S_PEND;
                    end
                end
            end
            S_UNI:
            begin
                cmd.take = accept;
                if (accept)
                begin
                    if (st.in_hex && st.cnt_full)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OSEL_CODE;
                        cmd.out_last = st.in_end;
                        state_next   = S_IDLE;
                    end
                    else if (st.in_hex && !st.in_end)
                    begin
                        cmd.store_digit = 1'b1;
                    end
                    else
                    begin
                        cmd.rep_clear = 1'b1;
                        state_next    = S_REPLAY;
                    end
                end
            end
            S_PEND:
            begin
                if (st.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_CUR;
                    cmd.out_last = st.cur_end;
                    state_next   = S_IDLE;
                end
            end
            S_REPLAY:
            begin
                if (st.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_HELD;
                    cmd.rep_inc  = 1'b1;
                    if (st.rep_last)
                    begin
                        state_next = S_RESCAN;
                    end
                end
            end
            S_RESCAN:
            begin
                // The unit that broke the \u escape is scanned as ordinary input.
                if (st.cur_bsl && !st.cur_end)
                begin
                    state_next = S_ESC;
                end
                else if (st.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_CUR;
                    cmd.out_last = st.cur_end;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/jsu_datapath.sv */
module jsu_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      code_unit,
    input  logic             end_of_text,
    input  jsu_pkg::cmd_t    cmd,
    output jsu_pkg::status_t st,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_unit,
    output logic             out_last
);
    import jsu_pkg::*;

    localparam int CNT_W = $clog2(HELD_DIGITS + 1);
    localparam int REP_W = $clog2(HELD_DIGITS + 2);
    localparam int IDX_W = $clog2(HELD_DIGITS);

    logic [15:0]      cur_unit_reg;
    logic             cur_end_reg;
    logic [15:0]      digit_reg [HELD_DIGITS];
    logic [CNT_W-1:0] cnt_reg;
    logic [REP_W-1:0] rep_reg;
    logic             out_valid_reg;
    logic [15:0]      out_unit_reg;
    logic             out_last_reg;
    logic [15:0]      out_unit_next;
    logic [15:0]      held_unit;
    logic [REP_W-1:0] rep_off;
    logic [15:0]      code_word;

    // Latched input item and held hex digits.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cur_unit_reg <= code_unit;
            cur_end_reg  <= end_of_text;
        end
        if (cmd.store_digit)
        begin
            digit_reg[cnt_reg[IDX_W-1:0]] <= code_unit;
        end
    end

    // Digit count and replay position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rep_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.store_digit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.rep_clear)
            begin
                rep_reg <= '0;
            end
            else if (cmd.rep_inc)
            begin
                rep_reg <= rep_reg + REP_W'(1);
            end
        end
    end

    // Held unit at the replay position: backslash, u, then the digits.
    assign rep_off = rep_reg - REP_W'(2);
    always_comb
    begin
        if (rep_reg == REP_W'(0))
        begin
            held_unit = CH_BSL;
        end
        else if (rep_reg == REP_W'(1))
        begin
            held_unit = CH_U;
        end
        else
        begin
            held_unit = digit_reg[rep_off[IDX_W-1:0]];
        end
    end

    // Code unit named by a complete \u escape.
    always_comb
    begin
        code_word = '0;
        for (int k = 0; k < HELD_DIGITS; k++)
        begin
            code_word = {code_word[11:0], hex_nibble(digit_reg[k])};
        end
        code_word = {code_word[11:0], hex_nibble(code_unit)};
    end

    // Output value selection.
    always_comb
    begin
        case (cmd.out_sel)
            OSEL_IN:   out_unit_next = code_unit;
            OSEL_MAP:  out_unit_next = simple_map(code_unit);
            OSEL_BSL:  out_unit_next = CH_BSL;
            OSEL_CODE: out_unit_next = code_word;
            OSEL_HELD: out_unit_next = held_unit;
            OSEL_CUR:  out_unit_next = cur_unit_reg;
            default:   out_unit_next = code_unit;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_unit_reg <= out_unit_next;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign out_last  = out_last_reg;

    // Status toward the controller.
    assign st.in_bsl    = (code_unit == CH_BSL);
    assign st.in_u      = (code_unit == CH_U);
    assign st.in_hex    = is_hex(code_unit);
    assign st.in_simple = is_simple(code_unit);
    assign st.in_end    = end_of_text;
    assign st.cur_bsl   = (cur_unit_reg == CH_BSL);
    assign st.cur_end   = cur_end_reg;
    assign st.cnt_full  = (cnt_reg == CNT_W'(HELD_DIGITS));
    assign st.rep_last  = (rep_reg == REP_W'(cnt_reg) + REP_W'(1));
    assign st.slot_free = !out_valid_reg || out_ready;

endmodule

/* hdl/json_string_unescaper.sv */
// JSON string unescaper: takes one 16-bit code unit per item and returns the
// unescaped text, with out_last on the final unit of each text. Ordinary units,
// one-character escapes and complete \u escapes give one result each through
// the single output register that the scanner loads at most once a cycle. An
// unknown escape gives its backslash first and then the unit itself. A failed
// \u escape replays its held units (two to five) from the digit registers, and
// then rescans the unit that broke it; no input is taken meanwhile.
module json_string_unescaper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_unit,
    output logic        out_last
);
    import jsu_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Scanner state machine.
    jsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Held digits, replay, decode and output register.
    jsu_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_unit    (out_unit),
        .out_last    (out_last)
    );

endmodule

/* hdl/jsu_checker.sv */
module jsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_unit,
    input logic        out_last
);

    // A result that waits keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(out_last))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid after reset");

    // An item is only taken when the output register has room for its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input ready while output register is blocked");

    // A result that was not taken while an item is offered is still offered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_valid |=> out_valid)
        else $error("stalled result dropped");

endmodule

bind json_string_unescaper jsu_checker u_checker (.*);

/* tb/tb.sv */
module tb;

    import jsu_pkg::*;

    // Characters used by the directed rows and the text generator.
    localparam logic [15:0] CH_0   = 16'h0030;
    localparam logic [15:0] CH_1   = 16'h0031;
    localparam logic [15:0] CH_2   = 16'h0032;
    localparam logic [15:0] CH_9   = 16'h0039;
    localparam logic [15:0] CH_A   = 16'h0041;
    localparam logic [15:0] CH_UPF = 16'h0046;
    localparam logic [15:0] CH_LOA = 16'h0061;
    localparam logic [15:0] CH_LOF = 16'h0066;
    localparam logic [15:0] CH_G   = 16'h0067;
    localparam logic [15:0] CH_Q   = 16'h0071;
    localparam logic [15:0] CH_LF  = 16'h000A;
    localparam logic [15:0] CH_NUL = 16'h0000;
    localparam logic [15:0] CH_MAX = 16'hFFFF;

    localparam int RANDOM_ITEMS = 180;
    localparam int HOLD_SLOTS   = 5;

    typedef enum logic [1:0] {
        SCAN_PLAIN,
        SCAN_ESCAPE,
        SCAN_UNICODE
    } scan_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } text_unit_t;

    // One input item, optionally with up to two results written out by hand.
    typedef struct packed {
        logic [15:0] unit;
        logic        eot;
        logic        typed;
        logic [1:0]  n_exp;
        logic [15:0] unit0;
        logic        last0;
        logic [15:0] unit1;
        logic        last1;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] code_unit = '0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_unit;
    logic        out_last;

    int          err_count = 0;
    stim_t       stim_items[$];
    text_unit_t  pending_units[$];
    text_unit_t  step_units[$];

    // Scanner state of the predictor.
    scan_t       scan = SCAN_PLAIN;
    logic [15:0] held [0:HOLD_SLOTS-1];
    int          held_n = 0;

    json_string_unescaper i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_unit    (out_unit),
        .out_last    (out_last)
    );

    always #4 clk = ~clk;

    // Strict hex digit test of the predictor.
    function automatic logic hex_ok(input logic [15:0] c);
        return (c inside {[CH_0:CH_9]}) || (c inside {[CH_A:CH_UPF]}) ||
               (c inside {[CH_LOA:CH_LOF]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [15:0] c);
        logic [15:0] v;
        if (c inside {[CH_0:CH_9]}) begin
            v = c - CH_0;
        end else if (c inside {[CH_A:CH_UPF]}) begin
            v = c - CH_A + 16'd10;
        end else begin
            v = c - CH_LOA + 16'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic short_escape_ok(input logic [15:0] c);
        return c inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    endfunction

    function automatic logic [15:0] short_escape_char(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if (c == CH_B) r = 16'h0008;
        if (c == CH_F) r = 16'h000C;
        if (c == CH_N) r = CH_LF;
        if (c == CH_R) r = 16'h000D;
        if (c == CH_T) r = 16'h0009;
        return r;
    endfunction

    task automatic emit(input logic [15:0] u, input logic l);
        text_unit_t t;
        t.unit = u;
        t.last = l;
        step_units.push_back(t);
    endtask

    // Unescape one code unit; its results land in step_units.
    task automatic unescape_unit(input logic [15:0] c, input logic eot);
        logic rescan;
        rescan = 1'b0;
        step_units.delete();
        case (scan)
            SCAN_ESCAPE:
            begin
                scan = SCAN_PLAIN;
                held_n = 0;
                if (short_escape_ok(c)) begin
                    emit(short_escape_char(c), eot);
                end else if (c == CH_U && !eot) begin
                    held[0] = CH_BSL;
                    held[1] = CH_U;
                    held_n = 2;
                    scan = SCAN_UNICODE;
                end else begin
                    emit(CH_BSL, 1'b0);
                    emit(c, eot);
                end
            end
            SCAN_UNICODE:
            begin
                if (hex_ok(c) && held_n >= HOLD_SLOTS) begin
                    emit({hex_val(held[2]), hex_val(held[3]), hex_val(held[4]), hex_val(c)},
                         eot);
                    scan = SCAN_PLAIN;
                    held_n = 0;
                end else if (hex_ok(c) && !eot) begin
                    held[held_n] = c;
                    held_n++;
                end else begin
                    for (int k = 0; k < held_n; k++) emit(held[k], 1'b0);
                    held_n = 0;
                    scan = SCAN_PLAIN;
                    rescan = 1'b1;
                end
            end
            default: rescan = 1'b1;
        endcase
        // Ordinary input, including the unit that broke a \u escape.
        if (rescan) begin
            if (c == CH_BSL && !eot) begin
                held[0] = CH_BSL;
                held_n = 1;
                scan = SCAN_ESCAPE;
            end else begin
                emit(c, eot);
            end
        end
    endtask

    task automatic add_row(input logic [15:0] u, input logic eot);
        stim_t s;
        s = '0;
        s.unit = u;
        s.eot = eot;
        stim_items.push_back(s);
    endtask

    task automatic add_typed(input logic [15:0] u, input logic eot, input logic [1:0] n,
                             input logic [15:0] u0, input logic l0,
                             input logic [15:0] u1, input logic l1);
        stim_t s;
        s.unit = u;
        s.eot = eot;
        s.typed = 1'b1;
        s.n_exp = n;
        s.unit0 = u0;
        s.last0 = l0;
        s.unit1 = u1;
        s.last1 = l1;
        stim_items.push_back(s);
    endtask

    function automatic logic [15:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return CH_0 + r[15:0];
        if (r < 16) return CH_LOA + r[15:0] - 16'd10;
        return CH_A + r[15:0] - 16'd16;
    endfunction

    function automatic logic [15:0] rand_short_escape();
        logic [15:0] pick [0:7];
        pick = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
        return pick[$urandom_range(0, 7)];
    endfunction

    function automatic logic [15:0] rand_plain();
        if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(16'h0020, 16'h007E));
    endfunction

    // Build one random text from plain and escape tokens; sometimes cut it short.
    task automatic gen_text();
        logic [15:0] txt[$];
        int          tokens;
        int          r;
        int          k;
        int          cut;
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                txt.push_back(rand_plain());
            end else if (r < 50) begin
                txt.push_back(CH_BSL);
                txt.push_back(rand_short_escape());
            end else if (r < 70) begin
                txt.push_back(CH_BSL);
                txt.push_back(CH_U);
                for (int d = 0; d < 4; d++) txt.push_back(rand_hex());
            end else if (r < 85) begin
                txt.push_back(CH_BSL);
                txt.push_back(CH_U);
                k = $urandom_range(0, 3);
                for (int d = 0; d < k; d++) txt.push_back(rand_hex());
                case ($urandom_range(0, 3))
                    0: txt.push_back(CH_BSL);
                    1: txt.push_back(CH_U);
                    2: txt.push_back(CH_QUOTE);
                    default: txt.push_back(rand_plain());
                endcase
            end else if (r < 95) begin
                txt.push_back(CH_BSL);
                txt.push_back(rand_plain());
            end else begin
                txt.push_back(CH_BSL);
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, txt.size());
            while (txt.size() > cut) void'(txt.pop_back());
        end
        for (int i = 0; i < txt.size(); i++) add_row(txt[i], i == txt.size() - 1);
    endtask

    // Idle lengths: mostly none or short, a few long.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        text_unit_t want;
        if (pending_units.size() == 0) begin
            $error("out_unit: unexpected result, actual 0x%h (out_last %0b)",
                   out_unit, out_last);
            err_count++;
        end else begin
            want = pending_units.pop_front();
            if (out_unit !== want.unit) begin
                $error("out_unit: expected 0x%h, actual 0x%h", want.unit, out_unit);
                err_count++;
            end
            if (out_last !== want.last) begin
                $error("out_last: expected %0b, actual %0b", want.last, out_last);
                err_count++;
            end
        end
    endtask

    // Reset once at the start.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender: directed table, then random texts.
    initial
    begin : feed
        int         idx;
        int         gap;
        int         pressure_at;
        bit         send_quiet;
        stim_t      it;
        text_unit_t tu;
        send_quiet = 1'b0;

        // Extremes and plain units after reset.
        add_typed(CH_A,   1'b1, 2'd1, CH_A,   1'b1, '0, 1'b0);
        add_typed(CH_NUL, 1'b0, 2'd1, CH_NUL, 1'b0, '0, 1'b0);
        add_typed(CH_MAX, 1'b1, 2'd1, CH_MAX, 1'b1, '0, 1'b0);
        // One-character escape.
        add_typed(CH_BSL, 1'b0, 2'd0, '0,     1'b0, '0, 1'b0);
        add_typed(CH_N,   1'b1, 2'd1, CH_LF,  1'b1, '0, 1'b0);
        // Lone trailing backslash.
        add_typed(CH_BSL, 1'b1, 2'd1, CH_BSL, 1'b1, '0, 1'b0);
        // Unknown escape passes both units.
        add_typed(CH_BSL, 1'b0, 2'd0, '0,     1'b0, '0, 1'b0);
        add_typed(CH_Q,   1'b1, 2'd2, CH_BSL, 1'b0, CH_Q, 1'b1);
        // Text ends right after the u of an escape.
        add_typed(CH_BSL, 1'b0, 2'd0, '0,     1'b0, '0, 1'b0);
        add_typed(CH_U,   1'b1, 2'd2, CH_BSL, 1'b0, CH_U, 1'b1);
        // Complete \u escape with mixed-case digits.
        add_row(CH_BSL, 1'b0);
        add_row(CH_U,   1'b0);
        add_row(CH_0,   1'b0);
        add_row(CH_LOA, 1'b0);
        add_row(CH_UPF, 1'b0);
        add_row(CH_9,   1'b1);
        // Non-hex unit breaks \u, then plain text goes on.
        add_row(CH_BSL, 1'b0);
        add_row(CH_U,   1'b0);
        add_row(CH_1,   1'b0);
        add_row(CH_G,   1'b0);
        // Text ends inside \u on a hex digit.
        add_row(CH_2,   1'b0);
        add_row(CH_BSL, 1'b0);
        add_row(CH_U,   1'b0);
        add_row(CH_2,   1'b1);
        // A backslash breaks \u and opens a new escape.
        add_row(CH_BSL, 1'b0);
        add_row(CH_U,   1'b0);
        add_row(CH_BSL, 1'b0);
        add_row(CH_T,   1'b1);

        pressure_at = stim_items.size() + RANDOM_ITEMS / 2;
        while (stim_items.size() < pressure_at + RANDOM_ITEMS / 2) gen_text();

        wait (rst_n);
        @(posedge clk);

        idx = 0;
        gap = pick_gap(send_quiet);
        while (idx < stim_items.size()) begin
            if (idx == pressure_at && gap == 0) gap = 1;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                // Once, let the block drain completely before going on.
                if (idx == pressure_at) begin
                    while (pending_units.size() != 0) @(posedge clk);
                end
            end
            it = stim_items[idx];
            in_valid    <= 1'b1;
            code_unit   <= it.unit;
            end_of_text <= it.eot;
            do @(posedge clk); while (!in_ready);

            // Item accepted at this edge: work out what it should produce.
            unescape_unit(it.unit, it.eot);
            if (it.typed) begin
                if (it.n_exp >= 2'd1) begin
                    tu.unit = it.unit0;
                    tu.last = it.last0;
                    pending_units.push_back(tu);
                end
                if (it.n_exp >= 2'd2) begin
                    tu.unit = it.unit1;
                    tu.last = it.last1;
                    pending_units.push_back(tu);
                end
            end else begin
                foreach (step_units[k]) pending_units.push_back(step_units[k]);
            end
            idx++;
            if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
            gap = pick_gap(send_quiet);
        end
        in_valid <= 1'b0;

        // Drain, then keep watching for stray results before finishing.
        while (pending_units.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: check each accepted result and stall at random.
    initial
    begin : drain
        int stall_left;
        int stall;
        bit recv_quiet;
        stall_left = 0;
        recv_quiet = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) check_result();
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 31) == 0) recv_quiet = !recv_quiet;
                stall = pick_gap(recv_quiet);
                if (stall == 0) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= 1'b0;
                    stall_left = stall - 1;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* json_string_unescaper.f */
hdl/jsu_pkg.sv
hdl/jsu_ctrl.sv
hdl/jsu_datapath.sv
hdl/json_string_unescaper.sv
hdl/jsu_checker.sv
tb/tb.sv
